/* sv/cbi_pkg.sv */
// Package with the controller state type and fixed constants of the breakpoint interpolator.
`default_nettype none
package cbi_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAN_W  = 3;
    localparam int unsigned PIDX_W  = 6;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned DVD_W   = VALUE_W + 1 + FRAC_W;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_END,
        S_MOD,
        S_UP_ISS,
        S_UP_CHK,
        S_DN_ISS,
        S_DN_CHK,
        S_F_ISS,
        S_F0,
        S_F1,
        S_SDIV,
        S_SLOPE,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

/* sv/cbi_if.sv */
// Handshake interfaces for the request and result channels of the interpolator.
`default_nettype none
interface cbi_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [2:0]  channel;
    logic [5:0]  pair_index;
    logic [31:0] break_time;
    logic signed [31:0] break_value;
    logic        last_pair;
    logic [31:0] sim_time;

    modport source (output valid, func, channel, pair_index, break_time, break_value,
                    last_pair, sim_time, input ready);
    modport sink (input valid, func, channel, pair_index, break_time, break_value,
                  last_pair, sim_time, output ready);
endinterface

interface cbi_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_channel;
    logic signed [31:0] value;
    logic        fault;

    modport source (output valid, out_channel, value, fault, input ready);
    modport sink (input valid, out_channel, value, fault, output ready);
endinterface
`default_nettype wire

/* sv/cyclic_breakpoint_interpolator_top.sv */
// Top level of the cyclic breakpoint interpolator: tables, cache, divider and controller.
//
//   Channel  Direction  Word contents
//   i_req    in         func, channel, pair_index, break_time, break_value, last_pair, sim_time
//   o_rsp    out        out_channel, value, fault (one word per evaluate, none per load)
//
// A load writes the tables as it is accepted. An evaluate whose time lies in the
// cached window goes straight to the multiply and the saturating add. A miss first
// reduces the time modulo the end time, one bit a cycle, then searches up or down for
// the interval through the breakpoint memory's registered read, fetches the two
// breakpoints, forms the slope quotient on the same divider, and ends with the
// multiply and the saturating add. A bad channel or a short table faults on
// acceptance, a zero end time once it is read, and a zero-length interval after the
// search. Reset is synchronous; the memories need no clearing.
// The block takes one word at a time; a finished result waits in the output register
// while the next word is accepted, and the controller stalls only when a second
// result is ready.
`default_nettype none
module cyclic_breakpoint_interpolator_top
    import cbi_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int MAX_PAIRS    = 64
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    cbi_req_if.sink   i_req,
    cbi_rsp_if.source o_rsp
);

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IP_W  = $clog2(MAX_PAIRS);
    localparam int PC_W  = $clog2(MAX_PAIRS + 1);
    localparam int DEPTH = NUM_CHANNELS * MAX_PAIRS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [AW-1:0] f_addr(input logic [CH_W-1:0] ch,
                                             input logic [IP_W-1:0] off);
        f_addr = AW'(AW'(ch) * AW'(MAX_PAIRS)) + AW'(off);
    endfunction

    // Breakpoint tables: one row of MAX_PAIRS entries per channel.
    logic [TIME_W-1:0]  m_kt [DEPTH];
    logic [VALUE_W-1:0] m_kv [DEPTH];
    logic [TIME_W-1:0]  r_rd_t;
    logic [VALUE_W-1:0] r_rd_v;

    // Per-channel pair count and cached interval.
    logic [PC_W-1:0]    r_pc   [NUM_CHANNELS];
    logic [IP_W-1:0]    r_cidx [NUM_CHANNELS];
    logic [TIME_W-1:0]  r_ub   [NUM_CHANNELS];
    logic [TIME_W-1:0]  r_lb   [NUM_CHANNELS];
    logic [VALUE_W-1:0] r_slp  [NUM_CHANNELS];
    logic [VALUE_W-1:0] r_icp  [NUM_CHANNELS];

    t_state r_state, n_state;

    logic [CH_W-1:0]    r_ch;
    logic [CHAN_W-1:0]  r_och;
    logic [TIME_W-1:0]  r_t;
    logic [PC_W-1:0]    r_n;
    logic [TIME_W-1:0]  r_mtime;
    logic [IP_W-1:0]    r_ip;
    logic [TIME_W-1:0]  r_t0;
    logic [VALUE_W-1:0] r_v0;
    logic [TIME_W-1:0]  r_t1;
    logic [VALUE_W-1:0] r_v1;
    logic               r_neg;
    logic               r_fault;
    logic [VALUE_W-1:0] r_res;
    logic signed [64:0] r_prod;
    logic [5:0]         r_cnt;

    // Shared restoring divider.
    logic [DVD_W-1:0]   r_dvd;
    logic [TIME_W:0]    r_rem;
    logic [TIME_W-1:0]  r_dsr;
    logic [DVD_W-1:0]   r_quo;

    logic               r_ov;
    logic [CHAN_W-1:0]  r_oc;
    logic [VALUE_W-1:0] r_oval;
    logic               r_of;

    logic               acc;
    logic               in_ch_ok;
    logic               in_pi_ok;
    logic [CH_W-1:0]    in_ch;
    logic [PC_W-1:0]    in_pc;
    logic [AW-1:0]      rd_addr;
    logic               out_free;

    assign in_ch    = CH_W'(i_req.channel);
    assign in_ch_ok = 32'(i_req.channel) < NUM_CHANNELS;
    assign in_pi_ok = 32'(i_req.pair_index) < MAX_PAIRS;
    assign in_pc    = r_pc[in_ch];
    assign acc      = i_req.valid && i_req.ready;
    assign out_free = !r_ov || o_rsp.ready;

    // Divider step.
    logic [TIME_W:0]    rem_sh;
    logic               rem_ge;
    logic [TIME_W:0]    rem_nx;
    assign rem_sh = {r_rem[TIME_W-1:0], r_dvd[DVD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dsr};
    assign rem_nx = rem_ge ? (rem_sh - {1'b0, r_dsr}) : rem_sh;

    // Hit test against the cached window.
    logic win_hit;
    assign win_hit = (r_t < r_ub[r_ch]) && (r_t >= r_lb[r_ch]);

    // Starting interval: the cached index clamped to the last interval.
    logic [IP_W-1:0] lim_ip, start_ip;
    assign lim_ip   = IP_W'(r_n - PC_W'(2));
    assign start_ip = (r_cidx[r_ch] > lim_ip) ? lim_ip : r_cidx[r_ch];

    // Interval differences for the slope.
    logic signed [TIME_W:0]  dt;
    logic signed [VALUE_W:0] dv;
    logic [TIME_W:0]         dt_abs;
    logic [VALUE_W:0]        dv_abs;
    assign dt     = $signed({1'b0, r_rd_t}) - $signed({1'b0, r_t0});
    assign dv     = $signed({r_rd_v[VALUE_W-1], r_rd_v}) - $signed({r_v0[VALUE_W-1], r_v0});
    assign dt_abs = dt[TIME_W] ? (TIME_W+1)'(-dt) : dt;
    assign dv_abs = dv[VALUE_W] ? (VALUE_W+1)'(-dv) : dv;

    // Slope saturation and window bounds.
    logic [VALUE_W-1:0] slope_sat;
    logic [TIME_W-1:0]  cyc;
    logic [TIME_W:0]    ub_sum, lb_sum;
    always_comb begin
        if (r_neg) begin
            slope_sat = (r_quo > DVD_W'(33'h080000000)) ? 32'h80000000
                                                       : VALUE_W'(-r_quo[VALUE_W-1:0]);
        end else begin
            slope_sat = (r_quo > DVD_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF
                                                      : r_quo[VALUE_W-1:0];
        end
    end
    assign cyc    = r_t - r_mtime;
    assign ub_sum = {1'b0, cyc} + {1'b0, r_t1};
    assign lb_sum = {1'b0, cyc} + {1'b0, r_t0};

    // Product and saturating sum. Dropping the low bits of the signed product
    // rounds toward minus infinity.
    logic signed [TIME_W:0] dtu;
    logic signed [49:0]     sum;
    logic [VALUE_W-1:0]     sum_sat;
    assign dtu = $signed({1'b0, r_t}) - $signed({1'b0, r_ub[r_ch]});
    assign sum = 50'($signed(r_prod[64:FRAC_W])) + 50'($signed(r_icp[r_ch]));
    always_comb begin
        if (!sum[49] && (|sum[48:31])) begin
            sum_sat = 32'h7FFFFFFF;
        end else if (sum[49] && !(&sum[48:31])) begin
            sum_sat = 32'h80000000;
        end else begin
            sum_sat = sum[31:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && i_req.func == FUNC_EVAL) begin
                    if (!in_ch_ok || in_pc < PC_W'(2)) n_state = S_DONE;
                    else n_state = S_END;
                end
            end
            S_END: begin
                if (r_rd_t == '0) n_state = S_DONE;
                else if (win_hit) n_state = S_MUL;
                else n_state = S_MOD;
            end
            S_MOD:    if (r_cnt == 6'd31) n_state = S_UP_ISS;
            S_UP_ISS: begin
                if (32'(r_ip) + 32'd2 < 32'(r_n)) n_state = S_UP_CHK;
                else n_state = S_DN_ISS;
            end
            S_UP_CHK: begin
                if (r_mtime >= r_rd_t) n_state = S_UP_ISS;
                else n_state = S_DN_ISS;
            end
            S_DN_ISS: begin
                if (r_ip != '0) n_state = S_DN_CHK;
                else n_state = S_F_ISS;
            end
            S_DN_CHK: begin
                if (r_mtime < r_rd_t) n_state = S_DN_ISS;
                else n_state = S_F_ISS;
            end
            S_F_ISS:  n_state = S_F0;
            S_F0:     n_state = S_F1;
            S_F1: begin
                if (dt == '0) n_state = S_DONE;
                else n_state = S_SDIV;
            end
            S_SDIV:   if (r_cnt == 6'(DVD_W - 1)) n_state = S_SLOPE;
            S_SLOPE:  n_state = S_MUL;
            S_MUL:    n_state = S_ADD;
            S_ADD:    n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs of the controller: ready and the memory read address.
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        rd_addr     = '0;
        unique case (r_state)
            S_IDLE:   rd_addr = f_addr(in_ch, IP_W'(in_pc - PC_W'(1)));
            S_UP_ISS: rd_addr = f_addr(r_ch, r_ip + IP_W'(1));
            S_DN_ISS: rd_addr = f_addr(r_ch, r_ip);
            S_F_ISS:  rd_addr = f_addr(r_ch, r_ip);
            S_F0:     rd_addr = f_addr(r_ch, r_ip + IP_W'(1));
            default:  rd_addr = '0;
        endcase
    end

    // Breakpoint memories.
    always_ff @(posedge i_clk) begin
        if (acc && i_req.func == FUNC_LOAD && in_ch_ok && in_pi_ok) begin
            m_kt[f_addr(in_ch, IP_W'(i_req.pair_index))] <= i_req.break_time;
            m_kv[f_addr(in_ch, IP_W'(i_req.pair_index))] <= i_req.break_value;
        end
        r_rd_t <= m_kt[rd_addr];
        r_rd_v <= m_kv[rd_addr];
    end

    // Control state and per-channel cache.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_pc[c]   <= '0;
                r_cidx[c] <= '0;
                r_ub[c]   <= '0;
                r_lb[c]   <= '0;
                r_slp[c]  <= '0;
                r_icp[c]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (acc && i_req.func == FUNC_LOAD && in_ch_ok && in_pi_ok) begin
                if (i_req.last_pair) r_pc[in_ch] <= PC_W'(i_req.pair_index) + PC_W'(1);
                r_cidx[in_ch] <= '0;
                r_ub[in_ch]   <= '0;
                r_lb[in_ch]   <= '0;
                r_slp[in_ch]  <= '0;
                r_icp[in_ch]  <= '0;
            end
            if (r_state == S_SLOPE) begin
                r_slp[r_ch]  <= slope_sat;
                r_icp[r_ch]  <= r_v1;
                r_ub[r_ch]   <= ub_sum[TIME_W] ? '1 : ub_sum[TIME_W-1:0];
                r_lb[r_ch]   <= lb_sum[TIME_W] ? '1 : lb_sum[TIME_W-1:0];
                r_cidx[r_ch] <= r_ip;
            end
            if (o_rsp.valid && o_rsp.ready) r_ov <= 1'b0;
            if (r_state == S_DONE && out_free) r_ov <= 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ch  <= in_ch;
            r_och <= i_req.channel;
            r_t   <= i_req.sim_time;
            r_n   <= in_pc;
        end
        if (n_state == S_DONE && r_state != S_DONE) r_fault <= (r_state != S_ADD);
        unique case (r_state)
            S_END: begin
                r_dvd <= {r_t, (DVD_W-TIME_W)'(0)};
                r_rem <= '0;
                r_dsr <= r_rd_t;
                r_cnt <= '0;
            end
            S_MOD: begin
                r_dvd <= r_dvd << 1;
                r_rem <= rem_nx;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_mtime <= rem_nx[TIME_W-1:0];
                    r_ip    <= start_ip;
                end
            end
            S_UP_CHK: if (r_mtime >= r_rd_t) r_ip <= r_ip + IP_W'(1);
            S_DN_CHK: if (r_mtime < r_rd_t) r_ip <= r_ip - IP_W'(1);
            S_F0: begin
                r_t0 <= r_rd_t;
                r_v0 <= r_rd_v;
            end
            S_F1: begin
                r_t1  <= r_rd_t;
                r_v1  <= r_rd_v;
                r_neg <= dv[VALUE_W] ^ dt[TIME_W];
                r_dvd <= {dv_abs, (DVD_W-VALUE_W-1)'(0)};
                r_rem <= '0;
                r_dsr <= dt_abs[TIME_W-1:0];
                r_quo <= '0;
                r_cnt <= '0;
            end
            S_SDIV: begin
                r_dvd <= r_dvd << 1;
                r_rem <= rem_nx;
                r_quo <= {r_quo[DVD_W-2:0], rem_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            S_MUL:  r_prod <= $signed(r_slp[r_ch]) * dtu;
            S_ADD:  r_res <= sum_sat;
            default: ;
        endcase
        if (r_state == S_DONE && out_free) begin
            r_oc   <= r_och;
            r_oval <= r_fault ? '0 : r_res;
            r_of   <= r_fault;
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.out_channel = r_oc;
    assign o_rsp.value       = r_oval;
    assign o_rsp.fault       = r_of;

endmodule
`default_nettype wire
